/* hdl/mssc_pkg.sv */
// Shared types, constants and digit helpers for the multiplexed seven-segment clock.
// No dependencies; imported by every module of the block except the checker.
`default_nettype none

package mssc_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int SCAN_W      = $clog2(DIGIT_COUNT);
   localparam int HOUR_W      = 5;
   localparam int MINUTE_W    = 6;
   localparam int SECOND_W    = 6;
   localparam int PERIOD_W    = 10;
   localparam int DIGIT_W     = 4;
   localparam int SEG_W       = 7;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;

   localparam logic [SEG_W-1:0]       SEG_OFF    = '1;
   localparam logic [DIGIT_COUNT-1:0] ENABLE_OFF = '1;

   localparam logic [HOUR_W-1:0]   RESET_HOUR      = 5'd15;
   localparam logic [MINUTE_W-1:0] RESET_MINUTE    = 6'd10;
   localparam logic [SECOND_W-1:0] RESET_SECOND    = 6'd0;
   localparam logic [PERIOD_W-1:0] RESET_SEC_PER   = 10'd100;
   localparam logic [PERIOD_W-1:0] RESET_SCAN_PER  = 10'd50;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_START_HOUR    = 3'd0,
      REG_START_MINUTE  = 3'd1,
      REG_START_SECOND  = 3'd2,
      REG_SECOND_PERIOD = 3'd3,
      REG_SCAN_PERIOD   = 3'd4
   } csr_reg_type;

   typedef logic [DIGIT_W-1:0]          digit_type;
   typedef digit_type [DIGIT_COUNT-1:0] digit_row_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // events already qualified by an accepted tick
   typedef struct packed {
      logic sec_event;
      logic scan_event;
   } tick_event_type;

   typedef struct packed {
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic                dot;
   } clock_status_type;

   typedef struct packed {
      logic [DIGIT_COUNT-1:0] enable_n;
      logic [SEG_W-1:0]       segments_n;
   } scan_status_type;

   // tens digit of a 6-bit value (0..63)
   function automatic digit_type tens_of(input logic [5:0] v);
      digit_type t;
      priority if (v >= 6'd60) t = 4'd6;
      else if (v >= 6'd50)     t = 4'd5;
      else if (v >= 6'd40)     t = 4'd4;
      else if (v >= 6'd30)     t = 4'd3;
      else if (v >= 6'd20)     t = 4'd2;
      else if (v >= 6'd10)     t = 4'd1;
      else                     t = 4'd0;
      return t;
   endfunction

   function automatic digit_type units_of(input logic [5:0] v);
      logic [5:0] t;
      logic [5:0] u;
      t = {2'b00, tens_of(v)};
      u = v - 6'(t * 6'd10);
      return u[DIGIT_W-1:0];
   endfunction

   // active-high segments, bit 0 = a; non-decimal codes are blank
   function automatic logic [SEG_W-1:0] segment_pattern(input digit_type d);
      logic [SEG_W-1:0] p;
      unique case (d)
         4'd0:    p = 7'b0111111;
         4'd1:    p = 7'b0000110;
         4'd2:    p = 7'b1011011;
         4'd3:    p = 7'b1001111;
         4'd4:    p = 7'b1100110;
         4'd5:    p = 7'b1101101;
         4'd6:    p = 7'b1111101;
         4'd7:    p = 7'b0000111;
         4'd8:    p = 7'b1111111;
         4'd9:    p = 7'b1101111;
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

/* hdl/multiplexed_seven_segment_clock.sv */
// Multiplexed seven-segment 24-hour clock, at most one base tick per transaction (req_tick).
// Path: input register, then result register, which drives rsp_valid; rsp_stall can hold both.
// Throughput: one transaction per cycle unless stalled; all state updates in one combinational pass.
// Reset (synchronous, active high): time 15:10:00, periods 100/50, digits 1,2,3,4,
// all digits and segments off, dot low, both pipeline registers empty.
// Depends on mssc_pkg, mssc_timebase, mssc_time_counter, mssc_scan.
`default_nettype none

module multiplexed_seven_segment_clock (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // tick channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_tick,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [mssc_pkg::DIGIT_COUNT-1:0]          rsp_digit_enable_n,
   output logic [mssc_pkg::SEG_W-1:0]                rsp_segments_n,
   output logic                                      rsp_dot_level,
   output logic [mssc_pkg::HOUR_W-1:0]               rsp_clock_hour,
   output logic [mssc_pkg::MINUTE_W-1:0]             rsp_clock_minute,
   output logic [mssc_pkg::SECOND_W-1:0]             rsp_clock_second,
   // configuration write channel
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [mssc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [mssc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import mssc_pkg::*;

   // input register
   logic in_valid_ff, in_valid_in;
   logic tick_ff;

   // result register
   logic             out_valid_ff, out_valid_in;
   clock_status_type clk_res_ff;
   scan_status_type  scan_res_ff;

   logic             advance;   // input register moves into result register
   logic             step;      // advance of a transaction that carries a tick
   csr_write_type    csr;
   tick_event_type   events;
   clock_status_type clk_status_in;
   scan_status_type  scan_status_in;
   digit_row_type    digits_in;

   // result register frees up when empty or when its transaction is taken
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign step      = advance && tick_ff;
   assign req_stall = in_valid_ff && !advance;

   // config only lands while no transaction is waiting in the input register
   assign csr_ready = !in_valid_ff;
   assign csr.valid = csr_valid && csr_ready;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         tick_ff <= req_tick;
      end
      if (advance) begin
         clk_res_ff  <= clk_status_in;
         scan_res_ff <= scan_status_in;
      end
   end

   mssc_timebase u_timebase (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .csr    (csr),
      .events (events)
   );

   mssc_time_counter u_time_counter (
      .clock     (clock),
      .reset     (reset),
      .sec_event (events.sec_event),
      .csr       (csr),
      .status_in (clk_status_in),
      .digits_in (digits_in)
   );

   // scan reads the refreshed digits, so a same-tick clock update shows at once
   mssc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .scan_event (events.scan_event),
      .digits     (digits_in),
      .status_in  (scan_status_in)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_digit_enable_n = scan_res_ff.enable_n;
   assign rsp_segments_n     = scan_res_ff.segments_n;
   assign rsp_dot_level      = clk_res_ff.dot;
   assign rsp_clock_hour     = clk_res_ff.hour;
   assign rsp_clock_minute   = clk_res_ff.minute;
   assign rsp_clock_second   = clk_res_ff.second;

endmodule

`default_nettype wire

/* hdl/mssc_timebase.sv */
// Second and scan countdowns with their period registers.
// Depends on mssc_pkg.
`default_nettype none

module mssc_timebase (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,
   input  wire mssc_pkg::csr_write_type csr,
   output mssc_pkg::tick_event_type    events
);
   import mssc_pkg::*;

   logic [PERIOD_W-1:0] sec_period_ff,  sec_period_in;
   logic [PERIOD_W-1:0] scan_period_ff, scan_period_in;
   logic [PERIOD_W-1:0] sec_count_ff,   sec_count_in;
   logic [PERIOD_W-1:0] scan_count_ff,  scan_count_in;

   // zero period behaves as one
   function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
      return (p == '0) ? PERIOD_W'(1) : p;
   endfunction

   assign events.sec_event  = step && (sec_count_ff <= PERIOD_W'(1));
   assign events.scan_event = step && (scan_count_ff <= PERIOD_W'(1));

   always_comb begin
      sec_period_in  = sec_period_ff;
      scan_period_in = scan_period_ff;
      sec_count_in   = sec_count_ff;
      scan_count_in  = scan_count_ff;
      if (step) begin
         sec_count_in  = events.sec_event  ? eff_period(sec_period_ff)
                                           : sec_count_ff - PERIOD_W'(1);
         scan_count_in = events.scan_event ? eff_period(scan_period_ff)
                                           : scan_count_ff - PERIOD_W'(1);
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_SECOND_PERIOD: begin
               sec_period_in = csr.data[PERIOD_W-1:0];
               sec_count_in  = eff_period(csr.data[PERIOD_W-1:0]);
            end
            REG_SCAN_PERIOD: begin
               scan_period_in = csr.data[PERIOD_W-1:0];
               scan_count_in  = eff_period(csr.data[PERIOD_W-1:0]);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_period_ff  <= RESET_SEC_PER;
         scan_period_ff <= RESET_SCAN_PER;
         sec_count_ff   <= eff_period(RESET_SEC_PER);
         scan_count_ff  <= eff_period(RESET_SCAN_PER);
      end else begin
         sec_period_ff  <= sec_period_in;
         scan_period_ff <= scan_period_in;
         sec_count_ff   <= sec_count_in;
         scan_count_ff  <= scan_count_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/mssc_time_counter.sv */
// 24-hour time counter, colon dot and HHMM digit store.
// Depends on mssc_pkg.
`default_nettype none

module mssc_time_counter (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    sec_event,
   input  wire mssc_pkg::csr_write_type csr,
   output mssc_pkg::clock_status_type   status_in,
   output mssc_pkg::digit_row_type      digits_in
);
   import mssc_pkg::*;

   logic [HOUR_W-1:0]   hour_ff,   hour_in;
   logic [MINUTE_W-1:0] minute_ff, minute_in;
   logic [SECOND_W-1:0] second_ff, second_in;
   logic                dot_ff,    dot_in;
   digit_row_type       digits_ff;

   logic [SECOND_W:0]   s_sum;
   logic [MINUTE_W:0]   m_sum;
   logic [HOUR_W:0]     h_sum;

   always_comb begin
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      dot_in    = dot_ff;
      digits_in = digits_ff;
      s_sum     = {1'b0, second_ff} + (SECOND_W+1)'(1);
      m_sum     = {1'b0, minute_ff};
      h_sum     = {1'b0, hour_ff};
      if (s_sum >= (SECOND_W+1)'(60)) begin
         s_sum = '0;
         m_sum = m_sum + (MINUTE_W+1)'(1);
      end
      if (m_sum >= (MINUTE_W+1)'(60)) begin
         m_sum = '0;
         h_sum = h_sum + (HOUR_W+1)'(1);
      end
      if (h_sum >= (HOUR_W+1)'(24)) begin
         h_sum = '0;
      end
      if (sec_event) begin
         second_in    = s_sum[SECOND_W-1:0];
         minute_in    = m_sum[MINUTE_W-1:0];
         hour_in      = h_sum[HOUR_W-1:0];
         dot_in       = ~dot_ff;
         digits_in[0] = tens_of({1'b0, h_sum[HOUR_W-1:0]});
         digits_in[1] = units_of({1'b0, h_sum[HOUR_W-1:0]});
         digits_in[2] = tens_of(m_sum[MINUTE_W-1:0]);
         digits_in[3] = units_of(m_sum[MINUTE_W-1:0]);
      end else if (csr.valid) begin
         unique case (csr.index)
            REG_START_HOUR:   hour_in   = csr.data[HOUR_W-1:0];
            REG_START_MINUTE: minute_in = csr.data[MINUTE_W-1:0];
            REG_START_SECOND: second_in = csr.data[SECOND_W-1:0];
            default: ;
         endcase
      end
   end

   assign status_in.hour   = hour_in;
   assign status_in.minute = minute_in;
   assign status_in.second = second_in;
   assign status_in.dot    = dot_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff      <= RESET_HOUR;
         minute_ff    <= RESET_MINUTE;
         second_ff    <= RESET_SECOND;
         dot_ff       <= 1'b0;
         digits_ff[0] <= 4'd1;
         digits_ff[1] <= 4'd2;
         digits_ff[2] <= 4'd3;
         digits_ff[3] <= 4'd4;
      end else begin
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         dot_ff    <= dot_in;
         digits_ff <= digits_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/mssc_scan.sv */
// Digit scan: position counter, enable and segment latches.
// Depends on mssc_pkg.
`default_nettype none

module mssc_scan (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    scan_event,
   input  wire mssc_pkg::digit_row_type digits,
   output mssc_pkg::scan_status_type    status_in
);
   import mssc_pkg::*;

   logic [SCAN_W-1:0]      pos_ff,      pos_in;
   logic [DIGIT_COUNT-1:0] enable_n_ff, enable_n_in;
   logic [SEG_W-1:0]       seg_n_ff,    seg_n_in;
   logic [DIGIT_COUNT-1:0] onehot;

   always_comb begin
      pos_in      = pos_ff;
      enable_n_in = enable_n_ff;
      seg_n_in    = seg_n_ff;
      onehot      = '0;
      onehot[pos_ff] = 1'b1;
      if (scan_event) begin
         enable_n_in = ~onehot;
         seg_n_in    = ~segment_pattern(digits[pos_ff]);
         pos_in      = (pos_ff == SCAN_W'(DIGIT_COUNT - 1)) ? '0 : pos_ff + SCAN_W'(1);
      end
   end

   assign status_in.enable_n   = enable_n_in;
   assign status_in.segments_n = seg_n_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         enable_n_ff <= ENABLE_OFF;
         seg_n_ff    <= SEG_OFF;
      end else begin
         pos_ff      <= pos_in;
         enable_n_ff <= enable_n_in;
         seg_n_ff    <= seg_n_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/mssc_checker.sv */
// Port-level assertions for multiplexed_seven_segment_clock, with its bind.
// No package dependencies.
`default_nettype none

module mssc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [3:0] rsp_digit_enable_n,
   input wire logic [6:0] rsp_segments_n,
   input wire logic [5:0] rsp_clock_second,
   input wire logic       csr_ready
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit_enable_n)
         && $stable(rsp_segments_n) && $stable(rsp_clock_second))
      else $error("stalled result changed");

   a_enable_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(~rsp_digit_enable_n))
      else $error("more than one digit enabled");

   a_blank_when_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_digit_enable_n == 4'hF) |-> (rsp_segments_n == 7'h7F))
      else $error("segments lit with no digit enabled");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !req_stall)
      else $error("config ready while tick pending");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind multiplexed_seven_segment_clock mssc_checker u_mssc_checker (.*);

`default_nettype wire
